/* hw/rtl/clw_pkg.sv */
package clw_pkg;

  // Input item kinds (carried on in_tuser)
  localparam logic MODE_ACC  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Field widths fixed by the stream format
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 10;
  localparam int LEVEL_W = 8;

  // BT.709 luma weights in Q16, summing to exactly 65536
  localparam int       Y16_W  = 24;
  localparam logic [15:0] COEF_R = 16'd13933;
  localparam logic [15:0] COEF_G = 16'd46871;
  localparam logic [15:0] COEF_B = 16'd4732;

  // Bin increment = DIVIDEND / height, kept modulo 256
  localparam int          DIV_W     = 11;
  localparam logic [10:0] DIVIDEND  = 11'd1024;
  localparam int          DIV_STEPS = 11;
  localparam int          DCNT_W    = 4;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PW    = 3;
  localparam int FIFO_CW    = 4;

  // Status from the increment divider
  typedef struct packed {
    logic               busy;
    logic [LEVEL_W-1:0] quot;
  } clw_div_stat_t;

endpackage

/* hw/rtl/clw_inc_div.sv */
module clw_inc_div import clw_pkg::*; #(
  parameter int HW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [HW-1:0] divisor,
  output clw_div_stat_t stat
);

  logic [DCNT_W-1:0] cnt_r;
  logic [HW-1:0]     dsr_r;
  logic [HW-1:0]     rem_r;
  logic [HW-1:0]     rem_nxt;
  logic [DIV_W-1:0]  dvd_r;
  logic [LEVEL_W-1:0] quot_r;
  logic [HW:0]       sh;
  logic [HW:0]       diff;
  logic              ge;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    sh      = {rem_r, dvd_r[DIV_W-1]};
    diff    = sh - {1'b0, dsr_r};
    ge      = (sh >= {1'b0, dsr_r});
    rem_nxt = ge ? diff[HW-1:0] : sh[HW-1:0];
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DCNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Datapath; quotient keeps only its low byte (wraps modulo 256)
  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r  <= divisor;
      rem_r  <= '0;
      dvd_r  <= DIVIDEND;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[DIV_W-2:0], 1'b0};
      quot_r <= {quot_r[LEVEL_W-2:0], ge};
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.quot = quot_r;

endmodule

/* hw/rtl/column_luma_waveform_top.sv */
// Per-column luma waveform histogram.
// in_*  : one item per transaction. in_tuser is the mode: 0 accumulates the
//         pixel in in_tdata into the bin picked by its BT.709 luma scaled to
//         the column height; 1 reads bin in_tdata[33:24] and clears it.
// out_* : one result per readout item, in order: the bin's level and number.
// cfg_* : column height write (1..1024; 0 acts as 1, above MAX_HEIGHT saturates).
//         Write only while no item is in flight.
// Throughput is one item per clock while in_tready is high. A readout result
// is written into the output queue from stage 4; out_tvalid shows the queue head.
// The bins live in one RAM that is read, updated and written back in a
// four-stage pipeline; the write of the previous cycle is forwarded.
// After reset the RAM is cleared one entry per cycle, over MAX_HEIGHT entries, with
// in_tready low. Each height write starts a divide for the bin increment,
// also holding in_tready low. When the receiver stalls, results wait in an
// 8-entry queue; in_tready drops once 8 readout results are owed, and then
// holds accumulate items as well as readouts.
module column_luma_waveform_top import clw_pkg::*; #(
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // cfg_data: column_height[10:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: red[7:0], green[15:8], blue[23:16], bin_index[33:24], zero pad
  input  logic [39:0] in_tdata,
  // in_tuser: mode[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: bin_level[7:0], bin_number[17:8], zero pad
  output logic [23:0] out_tdata
);

  localparam int AW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = (HW > IDX_W) ? HW : IDX_W;
  localparam int GW    = (HW > 11) ? HW : 11;
  localparam int PW    = Y16_W + HW;
  localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
  localparam int ENT_W = LEVEL_W + IDX_W;

  // ---------------- configuration ----------------
  logic [HW-1:0] h_r;
  logic [HW-1:0] h_nxt;
  logic [GW-1:0] ch_g;
  logic [GW-1:0] h_eff;
  logic          cfg_acc;
  logic          init_r;
  clw_div_stat_t div_stat;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  // Effective height: 0 acts as 1, saturate at MAX_HEIGHT
  always_comb begin
    ch_g = GW'(cfg_data);
    if (ch_g == '0) begin
      h_eff = GW'(1);
    end else if (ch_g > GW'(MAX_HEIGHT)) begin
      h_eff = GW'(MAX_HEIGHT);
    end else begin
      h_eff = ch_g;
    end
    h_nxt = cfg_acc ? h_eff[HW-1:0] : h_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r    <= HW'(H_RST);
      init_r <= 1'b1;
    end else begin
      h_r    <= h_nxt;
      init_r <= 1'b0;
    end
  end

  clw_inc_div #(.HW(HW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_acc | init_r),
    .divisor (h_nxt),
    .stat    (div_stat)
  );

  // ---------------- clearing pass ----------------
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(MAX_HEIGHT - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // ---------------- input acceptance ----------------
  logic [FIFO_CW-1:0] rsv_r;
  logic               in_acc;
  logic               out_acc;

  assign in_tready = !clr_active_r && !div_stat.busy && !init_r &&
                     (rsv_r < FIFO_CW'(FIFO_DEPTH));
  assign in_acc    = in_tvalid & in_tready;

  // ---------------- stage 1: captured item ----------------
  logic             s1_valid_r;
  logic             s1_mode_r;
  logic [PIX_W-1:0] s1_red_r;
  logic [PIX_W-1:0] s1_green_r;
  logic [PIX_W-1:0] s1_blue_r;
  logic [IDX_W-1:0] s1_idx_r;

  // ---------------- stage 2: luma ----------------
  logic             s2_valid_r;
  logic             s2_mode_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [Y16_W-1:0] s2_y16_r;
  logic [Y16_W-1:0] y16_nxt;

  // ---------------- stage 3: scaled luma, RAM read ----------------
  logic             s3_valid_r;
  logic             s3_mode_r;
  logic [IDX_W-1:0] s3_idx_r;
  logic [PW-1:0]    s3_prod_r;
  logic [PW-1:0]    prod_nxt;
  logic [HW-1:0]    bin_raw;
  logic [HW-1:0]    bin_cl;
  logic [CW-1:0]    idx_c;
  logic             s3_inrange;
  logic [AW-1:0]    rd_addr;

  // ---------------- stage 4: modify and write back ----------------
  logic               s4_valid_r;
  logic               s4_mode_r;
  logic               s4_inrange_r;
  logic [IDX_W-1:0]   s4_idx_r;
  logic [AW-1:0]      s4_addr_r;
  logic [LEVEL_W-1:0] rd_data_r;
  logic [LEVEL_W-1:0] cur_level;
  logic [LEVEL_W-1:0] upd_level;
  logic               push;

  // RAM write port and forwarding of last cycle's write
  logic [LEVEL_W-1:0] bins_mem [MAX_HEIGHT];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [LEVEL_W-1:0] mem_wdata;
  logic               fw_valid_r;
  logic [AW-1:0]      fw_addr_r;
  logic [LEVEL_W-1:0] fw_data_r;

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  // Stage 1 capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r  <= in_tuser;
      s1_red_r   <= in_tdata[7:0];
      s1_green_r <= in_tdata[15:8];
      s1_blue_r  <= in_tdata[23:16];
      s1_idx_r   <= in_tdata[33:24];
    end
  end

  // Q16 luma; the weights sum to 65536 so 24 bits never overflow
  assign y16_nxt = Y16_W'(COEF_R) * Y16_W'(s1_red_r) +
                   Y16_W'(COEF_G) * Y16_W'(s1_green_r) +
                   Y16_W'(COEF_B) * Y16_W'(s1_blue_r);

  always_ff @(posedge clk) begin
    s2_mode_r <= s1_mode_r;
    s2_idx_r  <= s1_idx_r;
    s2_y16_r  <= y16_nxt;
  end

  // Scale by column height
  assign prod_nxt = PW'(s2_y16_r) * PW'(h_r);

  always_ff @(posedge clk) begin
    s3_mode_r <= s2_mode_r;
    s3_idx_r  <= s2_idx_r;
    s3_prod_r <= prod_nxt;
  end

  // Bin select with clamp to height-1, or readout address
  always_comb begin
    bin_raw    = s3_prod_r[PW-1:Y16_W];
    bin_cl     = (bin_raw >= h_r) ? (h_r - 1'b1) : bin_raw;
    idx_c      = CW'(s3_idx_r);
    s3_inrange = (s3_mode_r == MODE_ACC) || (idx_c < CW'(MAX_HEIGHT));
    rd_addr    = (s3_mode_r == MODE_READ) ? idx_c[AW-1:0] : bin_cl[AW-1:0];
  end

  always_ff @(posedge clk) begin
    s4_mode_r    <= s3_mode_r;
    s4_idx_r     <= s3_idx_r;
    s4_inrange_r <= s3_inrange;
    s4_addr_r    <= rd_addr;
  end

  // Read-modify-write; forward the write made in the previous cycle
  always_comb begin
    cur_level = (fw_valid_r && fw_addr_r == s4_addr_r) ? fw_data_r : rd_data_r;
    upd_level = (s4_mode_r == MODE_READ) ? '0 : (cur_level + div_stat.quot);
    push      = s4_valid_r && (s4_mode_r == MODE_READ);
    if (clr_active_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = s4_valid_r && s4_inrange_r;
      mem_waddr = s4_addr_r;
      mem_wdata = upd_level;
    end
  end

  // Bin RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bins_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= bins_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_valid_r <= 1'b0;
    end else begin
      fw_valid_r <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    fw_addr_r <= mem_waddr;
    fw_data_r <= mem_wdata;
  end

  // ---------------- result queue ----------------
  logic [ENT_W-1:0]   fifo_mem [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_r;
  logic [FIFO_PW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] fifo_cnt_r;
  logic [ENT_W-1:0]   push_ent;
  logic [FIFO_CW-1:0] rsv_nxt;

  assign push_ent   = {s4_idx_r, (s4_inrange_r ? cur_level : LEVEL_W'(0))};
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_tdata  = {{(24 - ENT_W){1'b0}}, fifo_mem[rd_ptr_r]};
  assign out_acc    = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + FIFO_CW'(push) - FIFO_CW'(out_acc);
    end
  end

  // Results owed: reserved at acceptance, released at output transaction
  assign rsv_nxt = rsv_r + FIFO_CW'(in_acc && in_tuser == MODE_READ) - FIFO_CW'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsv_r <= '0;
    end else begin
      rsv_r <= rsv_nxt;
    end
  end

  // ---------------- checks ----------------
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !out_acc) |-> (fifo_cnt_r < FIFO_CW'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_rsv_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
    rsv_r >= fifo_cnt_r)
    else $error("reservation count below queue fill");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_acc)
    else $error("item accepted during clearing pass");

  a_no_pipe_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s4_valid_r)
    else $error("pipeline write during clearing pass");

  a_push_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> $past(s3_valid_r && s3_mode_r == MODE_READ))
    else $error("result pushed without a readout in flight");

endmodule
